FILE: hw/rtl/smp_pkg.sv
package smp_pkg;

    localparam int NUM_VERTICES_DEF = 64;
    localparam int NUM_MODES_DEF    = 32;

    localparam int REQ_TYPE_W = 3;
    localparam int ROW_W      = 8;
    localparam int COL_W      = 5;
    localparam int VAL_W      = 32;
    localparam int ANG_W      = 16;
    localparam int VTX_W      = 6;

    localparam int ACC_W        = 66;
    localparam int SAT_W        = 68;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [VAL_W-1:0]    ONE_Q16     = 32'sd65536;
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_MEAN    = 3'd0,
        REQ_BASIS   = 3'd1,
        REQ_WEIGHT  = 3'd2,
        REQ_POSE    = 3'd3,
        REQ_PROJECT = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_START,
        ST_ROT_WAIT,
        ST_COORD_RUN,
        ST_COORD_WB,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_OUT
    } st_t;

    typedef enum logic [3:0] {
        U_T, U_R0, U_R1, U_R3A, U_R3B, U_R4A, U_R4B, U_R5,
        U_XA, U_XB, U_XC, U_XD, U_YA, U_YB, U_YC, U_YD
    } uop_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_T, WB_R0, WB_R1, WB_R3, WB_R4, WB_R5, WB_U, WB_PX, WB_PY
    } wb_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clr;
        logic neg;
        logic rnd_term;
    } mac_ctl_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [CORDIC_W-1:0] a;
        unique case (i)
            5'd0:  a = 34'sh03243F6A8;
            5'd1:  a = 34'sh01DAC6705;
            5'd2:  a = 34'sh00FADBAFC;
            5'd3:  a = 34'sh007F56EA6;
            5'd4:  a = 34'sh003FEAB76;
            5'd5:  a = 34'sh001FFD55B;
            5'd6:  a = 34'sh000FFFAAA;
            5'd7:  a = 34'sh0007FFF55;
            5'd8:  a = 34'sh0003FFFEA;
            5'd9:  a = 34'sh0001FFFFD;
            5'd10: a = 34'sh0000FFFFF;
            5'd11: a = 34'sh00007FFFF;
            5'd12: a = 34'sh00003FFFF;
            5'd13: a = 34'sh00001FFFF;
            5'd14: a = 34'sh00000FFFF;
            5'd15: a = 34'sh000007FFF;
            5'd16: a = 34'sh000003FFF;
            5'd17: a = 34'sh000001FFF;
            5'd18: a = 34'sh000000FFF;
            5'd19: a = 34'sh0000007FF;
            5'd20: a = 34'sh0000003FF;
            5'd21: a = 34'sh0000001FF;
            5'd22: a = 34'sh0000000FF;
            5'd23: a = 34'sh00000007F;
            5'd24: a = 34'sh00000003F;
            5'd25: a = 34'sh00000001F;
            5'd26: a = 34'sh00000000F;
            5'd27: a = 34'sh000000008;
            5'd28: a = 34'sh000000004;
            5'd29: a = 34'sh000000002;
            default: a = '0;
        endcase
        return a;
    endfunction

    // bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [32:0] r;
        if (v > 68'sd2147483647)
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else if (v < -68'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/smp_if.sv
interface smp_req_if import smp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [ROW_W-1:0]        coord_row;
    logic [COL_W-1:0]        mode_col;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] scale;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] roll;
    logic signed [VAL_W-1:0] offset_x;
    logic signed [VAL_W-1:0] offset_y;
    logic [VTX_W-1:0]        vertex;

    modport source (
        output valid, req_type, coord_row, mode_col, value, scale,
               pitch, yaw, roll, offset_x, offset_y, vertex,
        input  ready
    );
    modport sink (
        input  valid, req_type, coord_row, mode_col, value, scale,
               pitch, yaw, roll, offset_x, offset_y, vertex,
        output ready
    );
endinterface

interface smp_rsp_if import smp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] point_x;
    logic signed [VAL_W-1:0] point_y;
    logic [VTX_W-1:0]        vertex_out;
    logic                    saturated;

    modport source (
        output valid, point_x, point_y, vertex_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, vertex_out, saturated,
        output ready
    );
endinterface

FILE: hw/rtl/smp_cordic.sv
module smp_cordic import smp_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    busy,
    output logic                    done,
    output logic signed [31:0]      sin_val,
    output logic signed [31:0]      cos_val
);

    logic                       run_reg;
    logic                       done_reg;
    logic [4:0]                 i_reg;
    logic                       neg_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;

    logic signed [CORDIC_W-1:0] z_raw;
    logic signed [CORDIC_W-1:0] z_start;
    logic                       neg_start;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] x_fin;
    logic signed [CORDIC_W-1:0] y_fin;

    always_comb
    begin
        z_raw = CORDIC_W'(angle) <<< 17;
        // fold into the right half plane, flip the signs at the end
        if (z_raw > HALF_PI_Q30)
        begin
            z_start   = z_raw - PI_Q30;
            neg_start = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q30)
        begin
            z_start   = z_raw + PI_Q30;
            neg_start = 1'b1;
        end
        else
        begin
            z_start   = z_raw;
            neg_start = 1'b0;
        end
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                if (i_reg == 5'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= GAIN_Q30;
            y_reg   <= '0;
            z_reg   <= z_start;
            neg_reg <= neg_start;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_q30(i_reg);
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_q30(i_reg);
            end
        end
    end

    assign x_fin   = neg_reg ? -x_reg : x_reg;
    assign y_fin   = neg_reg ? -y_reg : y_reg;
    assign cos_val = x_fin[31:0];
    assign sin_val = y_fin[31:0];
    assign busy    = run_reg;
    assign done    = done_reg;

endmodule

FILE: hw/rtl/smp_mac.sv
module smp_mac import smp_pkg::*; (
    input  logic                    clk,
    input  mac_ctl_t                ctl,
    input  logic signed [31:0]      a,
    input  logic signed [31:0]      b,
    input  logic signed [31:0]      init,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [63:0]      prod_reg;
    logic signed [63:0]      prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] p_ext;
    logic signed [ACC_W-1:0] term;

    assign prod_next = a * b;

    always_comb
    begin
        base  = ctl.clr ? ACC_W'(init) : acc_reg;
        p_ext = ACC_W'(prod_reg);
        if (ctl.rnd_term)
        begin
            term = (p_ext + 66'sd32768) >>> 16;
        end
        else
        begin
            term = ctl.neg ? -p_ext : p_ext;
        end
        acc_next = base + term;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hw/rtl/shape_model_projection.sv
// Shape model projection.
// req channel: one item per request. Mean, basis and weight writes and
// unknown or out-of-range requests finish as they are taken. A set-pose
// item runs three 30-step CORDIC passes and eight products. A project item
// walks the basis row of x, y and z through the shared multiply-accumulate,
// one mode per cycle, then does eight rotation and scale products.
// req.ready is high only while the block is idle.
// rsp channel: one point per in-range project item, held in an output
// register. If the receiver stalls, the next item is still taken, and a
// following point waits until the held one has been transferred.
// Reset clears the weights to zero, sets the rotation rows to identity,
// the scale to one and the offsets to zero. Mean and basis entries hold
// no value until written.
module shape_model_projection import smp_pkg::*; #(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF,
    parameter int NUM_MODES    = NUM_MODES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    smp_req_if.sink   req,
    smp_rsp_if.source rsp
);

    localparam int ROWS = 3 * NUM_VERTICES;
    localparam int VW   = $clog2(NUM_VERTICES > 1 ? NUM_VERTICES : 2);
    localparam int RW   = $clog2(ROWS);
    localparam int MW   = $clog2(NUM_MODES > 1 ? NUM_MODES : 2);
    localparam int BD   = ROWS * NUM_MODES;
    localparam int BW   = $clog2(BD);
    localparam logic [RW-1:0] NV_R    = RW'(NUM_VERTICES);
    localparam logic [MW-1:0] M_LAST  = MW'(NUM_MODES - 1);

    st_t  state_reg, state_next;
    uop_t uop_reg;

    logic [1:0]    ax_reg;
    logic [1:0]    ci_reg;
    logic [MW-1:0] m_reg;
    logic          issue_reg;
    logic          p1_valid, p1_first, p1_last;
    logic          p2_valid, p2_first, p2_last;
    logic          out_valid_reg;
    logic          flag_reg;

    logic [VW-1:0]           vertex_reg;
    logic signed [ANG_W-1:0] pitch_reg, yaw_reg, roll_reg;
    logic signed [31:0]      scale_reg, offx_reg, offy_reg;
    logic signed [31:0]      rot_reg [6];
    logic signed [31:0]      sa_reg, ca_reg, sb_reg, cb_reg, sc_reg, cc_reg;
    logic signed [31:0]      t_reg, u_reg, px_reg, py_reg;
    logic signed [31:0]      coord_reg [3];
    logic signed [31:0]      ox_reg, oy_reg;
    logic [VTX_W-1:0]        ovtx_reg;
    logic                    osat_reg;

    logic signed [31:0] mean_mem  [ROWS];
    logic signed [31:0] basis_mem [BD];
    logic signed [31:0] weight_reg [NUM_MODES];
    logic signed [31:0] mean_q, basis_q, w_q;

    logic          in_fire, row_ok, col_ok, vtx_ok;
    logic          mean_we, basis_we, weight_we, pose_go, proj_go;
    logic [RW-1:0] row_cur;
    logic [BW-1:0] basis_wa, basis_ra;

    logic                 cordic_start, cordic_busy, cordic_done;
    logic signed [ANG_W-1:0] cordic_angle;
    logic signed [31:0]   cordic_sin, cordic_cos;

    mac_ctl_t                mac_ctl;
    logic signed [31:0]      mac_a, mac_b, mac_init;
    logic signed [ACC_W-1:0] acc;

    logic signed [31:0] op_a, op_b;
    logic               op_clr, op_neg;
    wb_t                op_wb;

    logic signed [ACC_W-1:0] rnd44_full, rnd30_full;
    logic [32:0]             coord_sat, u_sat, p_sat;
    logic signed [31:0]      p_off, r2_val;
    logic                    out_load;

    // request decode
    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign row_ok    = 32'(req.coord_row) < ROWS;
    assign col_ok    = 32'(req.mode_col) < NUM_MODES;
    assign vtx_ok    = 32'(req.vertex) < NUM_VERTICES;
    assign mean_we   = in_fire && (req.req_type == REQ_MEAN) && row_ok;
    assign basis_we  = in_fire && (req.req_type == REQ_BASIS) && row_ok && col_ok;
    assign weight_we = in_fire && (req.req_type == REQ_WEIGHT) && col_ok;
    assign pose_go   = in_fire && (req.req_type == REQ_POSE);
    assign proj_go   = in_fire && (req.req_type == REQ_PROJECT) && vtx_ok;

    assign basis_wa = BW'(req.coord_row) * BW'(NUM_MODES) + BW'(req.mode_col);
    assign row_cur  = RW'(vertex_reg) + RW'(ci_reg) * NV_R;
    assign basis_ra = BW'(row_cur) * BW'(NUM_MODES) + BW'(m_reg);

    always_ff @(posedge clk)
    begin
        if (mean_we)
        begin
            mean_mem[RW'(req.coord_row)] <= req.value;
        end
        mean_q <= mean_mem[row_cur];
    end

    always_ff @(posedge clk)
    begin
        if (basis_we)
        begin
            basis_mem[basis_wa] <= req.value;
        end
        basis_q <= basis_mem[basis_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_MODES; k++)
            begin
                weight_reg[k] <= '0;
            end
        end
        else if (weight_we)
        begin
            weight_reg[MW'(req.mode_col)] <= req.value;
        end
    end

    always_ff @(posedge clk)
    begin
        w_q <= weight_reg[m_reg];
    end

    // shared units
    always_comb
    begin
        unique case (ax_reg)
            2'd0:    cordic_angle = pitch_reg;
            2'd1:    cordic_angle = yaw_reg;
            default: cordic_angle = roll_reg;
        endcase
    end

    assign cordic_start = (state_reg == ST_ROT_START);

    smp_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .busy    (cordic_busy),
        .done    (cordic_done),
        .sin_val (cordic_sin),
        .cos_val (cordic_cos)
    );

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_clr = 1'b0;
        op_neg = 1'b0;
        op_wb  = WB_NONE;
        unique case (uop_reg)
            U_T:   begin op_a = sa_reg; op_b = sb_reg; op_clr = 1'b1; op_wb = WB_T; end
            U_R0:  begin op_a = cb_reg; op_b = cc_reg; op_clr = 1'b1; op_wb = WB_R0; end
            U_R1:
            begin
                op_a = cb_reg; op_b = sc_reg; op_clr = 1'b1; op_neg = 1'b1; op_wb = WB_R1;
            end
            U_R3A: begin op_a = ca_reg; op_b = sc_reg; op_clr = 1'b1; end
            U_R3B: begin op_a = t_reg;  op_b = cc_reg; op_wb = WB_R3; end
            U_R4A: begin op_a = ca_reg; op_b = cc_reg; op_clr = 1'b1; end
            U_R4B: begin op_a = t_reg;  op_b = sc_reg; op_neg = 1'b1; op_wb = WB_R4; end
            U_R5:
            begin
                op_a = sa_reg; op_b = cb_reg; op_clr = 1'b1; op_neg = 1'b1; op_wb = WB_R5;
            end
            U_XA:  begin op_a = rot_reg[0]; op_b = coord_reg[0]; op_clr = 1'b1; end
            U_XB:  begin op_a = rot_reg[1]; op_b = coord_reg[1]; end
            U_XC:  begin op_a = rot_reg[2]; op_b = coord_reg[2]; op_wb = WB_U; end
            U_XD:  begin op_a = scale_reg;  op_b = u_reg; op_clr = 1'b1; op_wb = WB_PX; end
            U_YA:  begin op_a = rot_reg[3]; op_b = coord_reg[0]; op_clr = 1'b1; end
            U_YB:  begin op_a = rot_reg[4]; op_b = coord_reg[1]; end
            U_YC:  begin op_a = rot_reg[5]; op_b = coord_reg[2]; op_wb = WB_U; end
            U_YD:  begin op_a = scale_reg;  op_b = u_reg; op_clr = 1'b1; op_wb = WB_PY; end
        endcase
    end

    always_comb
    begin
        mac_ctl  = '0;
        mac_a    = op_a;
        mac_b    = op_b;
        mac_init = '0;
        priority if (state_reg == ST_COORD_RUN)
        begin
            mac_a            = basis_q;
            mac_b            = w_q;
            mac_init         = mean_q;
            mac_ctl.mul_en   = p1_valid;
            mac_ctl.acc_en   = p2_valid;
            mac_ctl.clr      = p2_first;
            mac_ctl.rnd_term = 1'b1;
        end
        else if (state_reg == ST_MUL)
        begin
            mac_ctl.mul_en = 1'b1;
        end
        else if (state_reg == ST_ACC)
        begin
            mac_ctl.acc_en = 1'b1;
            mac_ctl.clr    = op_clr;
            mac_ctl.neg    = op_neg;
        end
        else
        begin
            mac_ctl = '0;
        end
    end

    smp_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .init (mac_init),
        .acc  (acc)
    );

    // write-back arithmetic
    assign rnd44_full = (acc + (66'sd1 <<< 43)) >>> 44;
    assign rnd30_full = (acc + (66'sd1 <<< 29)) >>> 30;
    assign coord_sat  = sat32(SAT_W'(acc));
    assign u_sat      = sat32((SAT_W'(acc) + 68'sd32768) >>> 16);
    assign p_off      = (op_wb == WB_PY) ? offy_reg : offx_reg;
    assign p_sat      = sat32(((SAT_W'(acc) + 68'sd32768) >>> 16) + SAT_W'(p_off));
    assign r2_val     = 32'((33'(sb_reg) + 33'sd8192) >>> 14);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pose_go)
                begin
                    state_next = ST_ROT_START;
                end
                else if (proj_go)
                begin
                    state_next = ST_COORD_RUN;
                end
            end
            ST_ROT_START: state_next = ST_ROT_WAIT;
            ST_ROT_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = (ax_reg == 2'd2) ? ST_MUL : ST_ROT_START;
                end
            end
            ST_COORD_RUN:
            begin
                if (p2_valid && p2_last)
                begin
                    state_next = ST_COORD_WB;
                end
            end
            ST_COORD_WB:  state_next = (ci_reg == 2'd2) ? ST_MUL : ST_COORD_RUN;
            ST_MUL:       state_next = ST_ACC;
            ST_ACC:       state_next = (op_wb != WB_NONE) ? ST_WB : ST_MUL;
            ST_WB:
            begin
                priority if (uop_reg == U_R5)
                begin
                    state_next = ST_IDLE;
                end
                else if (uop_reg == U_YD)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg        <= '0;
            ci_reg        <= '0;
            m_reg         <= '0;
            issue_reg     <= 1'b0;
            p1_valid      <= 1'b0;
            p1_first      <= 1'b0;
            p1_last       <= 1'b0;
            p2_valid      <= 1'b0;
            p2_first      <= 1'b0;
            p2_last       <= 1'b0;
            uop_reg       <= U_T;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            // pipeline of the coordinate walk: issue, multiply, accumulate
            p1_valid <= (state_reg == ST_COORD_RUN) && issue_reg;
            p1_first <= (m_reg == '0);
            p1_last  <= (m_reg == M_LAST);
            p2_valid <= (state_reg == ST_COORD_RUN) && p1_valid;
            p2_first <= p1_first;
            p2_last  <= p1_last;

            if (pose_go)
            begin
                ax_reg <= '0;
            end
            if (proj_go)
            begin
                ci_reg    <= '0;
                m_reg     <= '0;
                issue_reg <= 1'b1;
                flag_reg  <= 1'b0;
            end

            if ((state_reg == ST_ROT_WAIT) && cordic_done)
            begin
                if (ax_reg == 2'd2)
                begin
                    uop_reg <= U_T;
                end
                else
                begin
                    ax_reg <= ax_reg + 2'd1;
                end
            end

            if ((state_reg == ST_COORD_RUN) && issue_reg)
            begin
                m_reg <= m_reg + MW'(1);
                if (m_reg == M_LAST)
                begin
                    issue_reg <= 1'b0;
                end
            end

            if (state_reg == ST_COORD_WB)
            begin
                flag_reg <= flag_reg | coord_sat[32];
                if (ci_reg == 2'd2)
                begin
                    uop_reg <= U_XA;
                end
                else
                begin
                    ci_reg    <= ci_reg + 2'd1;
                    m_reg     <= '0;
                    issue_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_ACC) && (op_wb == WB_NONE))
            begin
                uop_reg <= uop_t'(4'(uop_reg + 4'd1));
            end

            if (state_reg == ST_WB)
            begin
                if ((uop_reg != U_R5) && (uop_reg != U_YD))
                begin
                    uop_reg <= uop_t'(4'(uop_reg + 4'd1));
                end
                if (op_wb == WB_U)
                begin
                    flag_reg <= flag_reg | u_sat[32];
                end
                if ((op_wb == WB_PX) || (op_wb == WB_PY))
                begin
                    flag_reg <= flag_reg | p_sat[32];
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pose state with defined reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= ONE_Q16;
            offx_reg   <= '0;
            offy_reg   <= '0;
            rot_reg[0] <= ONE_Q16;
            rot_reg[1] <= '0;
            rot_reg[2] <= '0;
            rot_reg[3] <= '0;
            rot_reg[4] <= ONE_Q16;
            rot_reg[5] <= '0;
        end
        else
        begin
            if (pose_go)
            begin
                scale_reg <= req.scale;
                offx_reg  <= req.offset_x;
                offy_reg  <= req.offset_y;
            end
            if (state_reg == ST_WB)
            begin
                unique case (op_wb)
                    WB_R0: rot_reg[0] <= rnd44_full[31:0];
                    WB_R1: rot_reg[1] <= rnd44_full[31:0];
                    WB_R3: rot_reg[3] <= rnd44_full[31:0];
                    WB_R4: rot_reg[4] <= rnd44_full[31:0];
                    WB_R5:
                    begin
                        rot_reg[5] <= rnd44_full[31:0];
                        rot_reg[2] <= r2_val;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pose_go)
        begin
            pitch_reg <= req.pitch;
            yaw_reg   <= req.yaw;
            roll_reg  <= req.roll;
        end
        if (proj_go)
        begin
            vertex_reg <= VW'(req.vertex);
        end
        if ((state_reg == ST_ROT_WAIT) && cordic_done)
        begin
            unique case (ax_reg)
                2'd0:    begin sa_reg <= cordic_sin; ca_reg <= cordic_cos; end
                2'd1:    begin sb_reg <= cordic_sin; cb_reg <= cordic_cos; end
                default: begin sc_reg <= cordic_sin; cc_reg <= cordic_cos; end
            endcase
        end
        if (state_reg == ST_COORD_WB)
        begin
            coord_reg[ci_reg] <= coord_sat[31:0];
        end
        if (state_reg == ST_WB)
        begin
            unique case (op_wb)
                WB_T:    t_reg  <= rnd30_full[31:0];
                WB_U:    u_reg  <= u_sat[31:0];
                WB_PX:   px_reg <= p_sat[31:0];
                WB_PY:   py_reg <= p_sat[31:0];
                default: ;
            endcase
        end
        if (out_load)
        begin
            ox_reg   <= px_reg;
            oy_reg   <= py_reg;
            ovtx_reg <= VTX_W'(vertex_reg);
            osat_reg <= flag_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.point_x    = ox_reg;
    assign rsp.point_y    = oy_reg;
    assign rsp.vertex_out = ovtx_reg;
    assign rsp.saturated  = osat_reg;

    a_cordic_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_start |-> !cordic_busy)
        else $error("CORDIC restarted while running");

    a_coord_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid |-> (state_reg == ST_COORD_RUN))
        else $error("accumulate stage live outside the coordinate walk");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished projection");

    a_wb_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> $past(state_reg == ST_ACC))
        else $error("write-back without a preceding accumulate");

endmodule
